[design/sbhtc_pkg.sv]
// Shared types, codes and helpers for the serial bus host transaction controller.
// No dependencies.
package sbhtc_pkg;

    localparam int BUFFER_WORDS_DEF = 256;

    localparam int ACTION_W  = 3;
    localparam int PHASE_W   = 3;
    localparam int OUTCOME_W = 3;
    localparam int FAILURE_W = 3;
    localparam int TIMER_W   = 24;
    localparam int GAP_W     = 16;
    localparam int WORD_W    = 32;
    localparam int PWORDS_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    localparam logic [GAP_W-1:0]   GAP_MAX          = 16'hFFFF;
    localparam logic               NET_ORDER_RST    = 1'b1;
    localparam logic [GAP_W-1:0]   INTER_WORD_RST   = 16'd300;
    localparam logic [TIMER_W-1:0] WRITE_LIMIT_RST  = 24'd2000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START_WRITE = 3'd0,
        ACT_START_READ  = 3'd1,
        ACT_TX_DONE     = 3'd2,
        ACT_RX_MARKER   = 3'd3,
        ACT_RX_WORD     = 3'd4,
        ACT_TICK        = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NET_ORDER   = 2'd0,
        REG_INTER_WORD  = 2'd1,
        REG_WRITE_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_WRITING    = 6'b000010,
        ST_WRITE_DONE = 6'b000100,
        ST_AWAIT_READ = 6'b001000,
        ST_READING    = 6'b010000,
        ST_READ_DONE  = 6'b100000
    } state_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE       = 3'd0,
        PH_WRITING    = 3'd1,
        PH_WRITE_DONE = 3'd2,
        PH_AWAIT_READ = 3'd3,
        PH_READING    = 3'd4,
        PH_READ_DONE  = 3'd5
    } phase_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_NONE        = 3'd0,
        OC_WRITE_DONE  = 3'd1,
        OC_READ_OK     = 3'd2,
        OC_READ_FAIL   = 3'd3,
        OC_WRITE_FAIL  = 3'd4
    } outcome_t;

    typedef enum logic [FAILURE_W-1:0] {
        FL_NONE     = 3'd0,
        FL_CHECK    = 3'd1,
        FL_MISSING  = 3'd2,
        FL_OVERFLOW = 3'd3,
        FL_TIMEOUT  = 3'd4
    } failure_t;

    typedef struct packed {
        logic [PWORDS_W-1:0] packet_words;
        failure_t            failure;
        outcome_t            outcome;
        phase_t              phase;
        logic                accepted;
    } result_t;

    function automatic phase_t phase_code(input state_t st);
        phase_t p;
        unique case (st)
            ST_IDLE:       p = PH_IDLE;
            ST_WRITING:    p = PH_WRITING;
            ST_WRITE_DONE: p = PH_WRITE_DONE;
            ST_AWAIT_READ: p = PH_AWAIT_READ;
            ST_READING:    p = PH_READING;
            ST_READ_DONE:  p = PH_READ_DONE;
            default:       p = PH_IDLE;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] byte_xor(input logic [WORD_W-1:0] w);
        return w[7:0] ^ w[15:8] ^ w[23:16] ^ w[31:24];
    endfunction

    function automatic logic [7:0] pick_byte(input logic net_order,
                                             input logic [WORD_W-1:0] w);
        return net_order ? w[31:24] : w[7:0];
    endfunction

endpackage

[design/serial_bus_host_transaction_control_core.sv]
// Results of accepted transactions are registered in the output register or skid entry.
// Throughput: one transaction per cycle while no result waits in the skid entry; a two-entry
// output buffer keeps s_tready high while one finished result waits on m_tready.
// Reset: aresetn synchronous, active low; phase idle, timers and read state cleared,
// registers back to network order 1, inter-word limit 300, write limit 2000.
// Depends on sbhtc_pkg.
module serial_bus_host_transaction_control_core
    import sbhtc_pkg::*;
#(
    parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // data_word[31:0], expect_response[32],
                                             // timeout_ticks[56:33], lines_high[57], zeros
    input  logic [ACTION_W-1:0]   s_tuser,   // action[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // accepted[0], phase[3:1], outcome[6:4],
                                             // failure[9:7], packet_words[17:10], zeros
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(BUFFER_WORDS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_WORDS);

    logic                 net_order_reg;
    logic [GAP_W-1:0]     inter_word_reg;
    logic [TIMER_W-1:0]   write_limit_reg;

    state_t               state_reg, state_next;
    logic                 want_reply_reg, want_reply_next;
    logic [TIMER_W-1:0]   reply_tmo_reg, reply_tmo_next;
    logic [TIMER_W-1:0]   kill_reg, kill_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;
    logic [CNT_W-1:0]     wcnt_reg, wcnt_next;
    logic [7:0]           xor_reg, xor_next;
    logic [WORD_W-1:0]    first_reg, first_next;
    logic [WORD_W-1:0]    last_reg, last_next;

    logic                 out_valid_reg, skid_valid_reg;
    result_t              out_data_reg, skid_data_reg;
    result_t              res;

    logic                 s_accept, m_take;
    action_t              action;
    logic [WORD_W-1:0]    data_word;
    logic                 expect_response;
    logic [TIMER_W-1:0]   timeout_ticks;
    logic                 lines_high;

    logic [GAP_W-1:0]     gap_inc;
    logic [TIMER_W-1:0]   kill_dec;
    logic [9:0]           len_need;

    assign action          = action_t'(s_tuser);
    assign data_word       = s_tdata[31:0];
    assign expect_response = s_tdata[32];
    assign timeout_ticks   = s_tdata[56:33];
    assign lines_high      = s_tdata[57];

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_take    = out_valid_reg && m_tready;
    assign m_tdata   = M_TDATA_W'(out_data_reg);
    assign cfg_ready = 1'b1;

    assign gap_inc  = (gap_reg != GAP_MAX) ? gap_reg + GAP_W'(1) : gap_reg;
    assign kill_dec = kill_reg - TIMER_W'(1);
    assign len_need = 10'(pick_byte(net_order_reg, first_reg)) + 10'd2;

    always_comb begin
        state_next      = state_reg;
        want_reply_next = want_reply_reg;
        reply_tmo_next  = reply_tmo_reg;
        kill_next       = kill_reg;
        gap_next        = gap_reg;
        wcnt_next       = wcnt_reg;
        xor_next        = xor_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        res             = '0;
        res.outcome     = OC_NONE;
        res.failure     = FL_NONE;

        if (s_accept) begin
            case (action)
                ACT_START_WRITE: begin
                    if (state_reg == ST_IDLE && lines_high) begin
                        res.accepted    = 1'b1;
                        want_reply_next = expect_response;
                        reply_tmo_next  = timeout_ticks;
                        kill_next       = write_limit_reg;
                        gap_next        = '0;
                        wcnt_next       = '0;
                        xor_next        = '0;
                        first_next      = '0;
                        last_next       = '0;
                        state_next      = ST_WRITING;
                    end
                end
                ACT_START_READ: begin
                    if (state_reg == ST_IDLE) begin
                        res.accepted = 1'b1;
                        kill_next    = timeout_ticks;
                        gap_next     = '0;
                        wcnt_next    = '0;
                        xor_next     = '0;
                        first_next   = '0;
                        last_next    = '0;
                        state_next   = ST_AWAIT_READ;
                    end
                end
                ACT_TX_DONE: begin
                    if (state_reg == ST_WRITING) begin
                        if (want_reply_reg) begin
                            kill_next  = reply_tmo_reg;
                            gap_next   = '0;
                            wcnt_next  = '0;
                            xor_next   = '0;
                            first_next = '0;
                            last_next  = '0;
                            state_next = ST_AWAIT_READ;
                        end else begin
                            kill_next  = '0;
                            state_next = ST_WRITE_DONE;
                        end
                    end
                end
                ACT_RX_MARKER: begin
                    if (state_reg == ST_AWAIT_READ) begin
                        gap_next   = '0;
                        state_next = ST_READING;
                    end else if (state_reg == ST_READING) begin
                        state_next = ST_READ_DONE;
                    end
                end
                ACT_RX_WORD: begin
                    if (state_reg == ST_READING && wcnt_reg < CNT_FULL) begin
                        if (wcnt_reg == '0) begin
                            first_next = data_word;
                        end else begin
                            xor_next = xor_reg ^ byte_xor(last_reg);
                        end
                        last_next = data_word;
                        wcnt_next = wcnt_reg + CNT_W'(1);
                        gap_next  = '0;
                    end
                end
                ACT_TICK: begin
                    if (state_reg == ST_READ_DONE) begin
                        if (wcnt_reg > CNT_W'(1) && len_need <= 10'(wcnt_reg)) begin
                            if (xor_reg == pick_byte(net_order_reg, last_reg)) begin
                                res.outcome      = OC_READ_OK;
                                res.packet_words = PWORDS_W'(wcnt_reg - CNT_W'(1));
                            end else begin
                                res.outcome = OC_READ_FAIL;
                                res.failure = FL_CHECK;
                            end
                        end else begin
                            res.outcome = OC_READ_FAIL;
                            res.failure = FL_MISSING;
                        end
                        state_next = ST_IDLE;
                    end else if (state_reg == ST_WRITE_DONE) begin
                        res.outcome = OC_WRITE_DONE;
                        state_next  = ST_IDLE;
                    end else if (state_reg == ST_READING) begin
                        if (wcnt_reg >= CNT_FULL) begin
                            res.outcome = OC_READ_FAIL;
                            res.failure = FL_OVERFLOW;
                            state_next  = ST_IDLE;
                        end else begin
                            gap_next = gap_inc;
                            if (gap_inc >= inter_word_reg) begin
                                res.outcome = OC_READ_FAIL;
                                res.failure = FL_TIMEOUT;
                                state_next  = ST_IDLE;
                            end
                        end
                    end else if (state_reg == ST_WRITING || state_reg == ST_AWAIT_READ) begin
                        if (kill_reg != '0) begin
                            kill_next = kill_dec;
                            if (kill_dec == '0) begin
                                res.outcome = (state_reg == ST_WRITING) ? OC_WRITE_FAIL
                                                                        : OC_READ_FAIL;
                                res.failure = FL_TIMEOUT;
                                state_next  = ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res.phase = phase_code(state_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            net_order_reg   <= NET_ORDER_RST;
            inter_word_reg  <= INTER_WORD_RST;
            write_limit_reg <= WRITE_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NET_ORDER:   net_order_reg   <= cfg_data[0];
                REG_INTER_WORD:  inter_word_reg  <= cfg_data[GAP_W-1:0];
                REG_WRITE_LIMIT: write_limit_reg <= cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            want_reply_reg <= 1'b0;
            reply_tmo_reg  <= '0;
            kill_reg       <= '0;
            gap_reg        <= '0;
            wcnt_reg       <= '0;
            xor_reg        <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            want_reply_reg <= want_reply_next;
            reply_tmo_reg  <= reply_tmo_next;
            kill_reg       <= kill_next;
            gap_reg        <= gap_next;
            wcnt_reg       <= wcnt_next;
            xor_reg        <= xor_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
        end
    end

    // output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_take) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!out_valid_reg || m_take) begin
                out_data_reg  <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

[design/sbhtc_checker.sv]
// Port-level checks for serial_bus_host_transaction_control_core, bound into each instance of it.
// Depends on sbhtc_pkg.
module sbhtc_checker
    import sbhtc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    result_t r;
    assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_failure_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.failure != FL_NONE |->
            r.outcome == OC_READ_FAIL || r.outcome == OC_WRITE_FAIL)
        else $error("failure without failing outcome");

    a_words_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.packet_words != '0 |-> r.outcome == OC_READ_OK)
        else $error("packet words outside read ok");

    a_accept_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.accepted |->
            r.phase == PH_WRITING || r.phase == PH_AWAIT_READ)
        else $error("accepted start in wrong phase");

    a_outcome_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.outcome != OC_NONE |-> r.phase == PH_IDLE && !r.accepted)
        else $error("completion not back in idle");

endmodule

bind serial_bus_host_transaction_control_core sbhtc_checker u_sbhtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
// Self-checking bench for serial_bus_host_transaction_control_core: directed event table,
// full-buffer reads, then random transaction traffic under four idle/stall mixes.
// Depends on sbhtc_pkg and the core; results checked against table rows or a local model.
`timescale 1ns / 1ps

module tb;
    import sbhtc_pkg::*;

    localparam int BUF_WORDS   = BUFFER_WORDS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACTION_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    serial_bus_host_transaction_control_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // controller model state and register copies
    logic                 reg_net       = NET_ORDER_RST;
    logic [GAP_W-1:0]     reg_gap_lim   = INTER_WORD_RST;
    logic [TIMER_W-1:0]   reg_wr_lim    = WRITE_LIMIT_RST;
    phase_t               ctl_phase     = PH_IDLE;
    logic                 ctl_reply     = 1'b0;
    logic [TIMER_W-1:0]   ctl_reply_tmo = '0;
    logic [TIMER_W-1:0]   ctl_kill      = '0;
    logic [GAP_W-1:0]     ctl_gap       = '0;
    int                   ctl_nwords    = 0;
    logic [7:0]           ctl_xor       = '0;
    logic [WORD_W-1:0]    ctl_head      = '0;
    logic [WORD_W-1:0]    ctl_tail      = '0;

    result_t pending_status[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_len = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      cfg_writes = 0;
    int      mismatches = 0;
    int      oc_seen[8];
    int      fl_seen[8];

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [WORD_W-1:0]   data;
        logic                er;
        logic [TIMER_W-1:0]  tmo;
        logic                lines;
        bit                  typed;
        result_t             want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic logic [7:0] fold_xor(input logic [WORD_W-1:0] w);
        return w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
    endfunction

    function automatic logic [7:0] key_byte(input logic [WORD_W-1:0] w);
        return reg_net ? w[31:24] : w[7:0];
    endfunction

    function automatic logic [WORD_W-1:0] place_byte(input logic [WORD_W-1:0] w,
                                                     input logic [7:0] b);
        return reg_net ? {b, w[23:0]} : {w[31:8], b};
    endfunction

    function automatic void clear_rx();
        ctl_gap    = '0;
        ctl_nwords = 0;
        ctl_xor    = '0;
        ctl_head   = '0;
        ctl_tail   = '0;
    endfunction

    function automatic result_t predict_status(input logic [ACTION_W-1:0] act,
                                               input logic [WORD_W-1:0] d,
                                               input logic er,
                                               input logic [TIMER_W-1:0] tmo,
                                               input logic lines);
        result_t r;
        r = '0;
        case (act)
            ACT_START_WRITE: begin
                if (ctl_phase == PH_IDLE && lines) begin
                    r.accepted    = 1'b1;
                    ctl_reply     = er;
                    ctl_reply_tmo = tmo;
                    ctl_kill      = reg_wr_lim;
                    clear_rx();
                    ctl_phase     = PH_WRITING;
                end
            end
            ACT_START_READ: begin
                if (ctl_phase == PH_IDLE) begin
                    r.accepted = 1'b1;
                    ctl_kill   = tmo;
                    clear_rx();
                    ctl_phase  = PH_AWAIT_READ;
                end
            end
            ACT_TX_DONE: begin
                if (ctl_phase == PH_WRITING) begin
                    if (ctl_reply) begin
                        ctl_kill  = ctl_reply_tmo;
                        clear_rx();
                        ctl_phase = PH_AWAIT_READ;
                    end else begin
                        ctl_kill  = '0;
                        ctl_phase = PH_WRITE_DONE;
                    end
                end
            end
            ACT_RX_MARKER: begin
                if (ctl_phase == PH_AWAIT_READ) begin
                    ctl_gap   = '0;
                    ctl_phase = PH_READING;
                end else if (ctl_phase == PH_READING) begin
                    ctl_phase = PH_READ_DONE;
                end
            end
            ACT_RX_WORD: begin
                if (ctl_phase == PH_READING && ctl_nwords < BUF_WORDS) begin
                    if (ctl_nwords == 0) ctl_head = d;
                    else ctl_xor = ctl_xor ^ fold_xor(ctl_tail);
                    ctl_tail = d;
                    ctl_nwords++;
                    ctl_gap = '0;
                end
            end
            ACT_TICK: begin
                if (ctl_phase == PH_READ_DONE) begin
                    if (ctl_nwords > 1 && key_byte(ctl_head) <= ctl_nwords - 2) begin
                        if (ctl_xor == key_byte(ctl_tail)) begin
                            r.outcome      = OC_READ_OK;
                            r.packet_words = 8'(ctl_nwords - 1);
                        end else begin
                            r.outcome = OC_READ_FAIL;
                            r.failure = FL_CHECK;
                        end
                    end else begin
                        r.outcome = OC_READ_FAIL;
                        r.failure = FL_MISSING;
                    end
                    ctl_phase = PH_IDLE;
                end else if (ctl_phase == PH_WRITE_DONE) begin
                    r.outcome = OC_WRITE_DONE;
                    ctl_phase = PH_IDLE;
                end else if (ctl_phase == PH_READING) begin
                    if (ctl_nwords >= BUF_WORDS) begin
                        r.outcome = OC_READ_FAIL;
                        r.failure = FL_OVERFLOW;
                        ctl_phase = PH_IDLE;
                    end else begin
                        if (ctl_gap != GAP_MAX) ctl_gap++;
                        if (ctl_gap >= reg_gap_lim) begin
                            r.outcome = OC_READ_FAIL;
                            r.failure = FL_TIMEOUT;
                            ctl_phase = PH_IDLE;
                        end
                    end
                end else if (ctl_phase == PH_WRITING || ctl_phase == PH_AWAIT_READ) begin
                    if (ctl_kill != '0) begin
                        ctl_kill--;
                        if (ctl_kill == '0) begin
                            r.outcome = (ctl_phase == PH_WRITING) ? OC_WRITE_FAIL : OC_READ_FAIL;
                            r.failure = FL_TIMEOUT;
                            ctl_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.phase = ctl_phase;
        return r;
    endfunction

    // ---------------- stimulus ----------------

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] data,
                             input logic er, input logic [TIMER_W-1:0] tmo, input logic lines,
                             input bit typed, input result_t want);
        result_t pred;
        int      gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, lines, tmo, er, data};
        do @(posedge aclk); while (!s_tready);
        pred = predict_status(act, data, er, tmo, lines);
        pending_status.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic put(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] data,
                       input logic er, input logic [TIMER_W-1:0] tmo, input logic lines);
        send_item(act, data, er, tmo, lines, 1'b0, '0);
    endtask

    task automatic pulse(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] data);
        put(act, data, 1'($urandom_range(0, 1)), 24'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    task automatic tick_run(input int k);
        repeat (k) pulse(ACT_TICK, $urandom());
    endtask

    function automatic logic [TIMER_W-1:0] pick_tmo();
        int r;
        r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 80) return 24'($urandom_range(1, 5));
        return 24'($urandom());
    endfunction

    // well-formed words get a legal length byte and a matching check byte
    task automatic read_words(input int n, input bit good, input bit gaps);
        logic [WORD_W-1:0] w;
        logic [7:0]        acc;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            w = $urandom();
            if (good && i == 0) w = place_byte(w, 8'($urandom_range(0, (n > 1) ? n - 2 : 0)));
            if (good && i == n - 1 && i > 0) w = place_byte(w, acc);
            if (i != n - 1) acc = acc ^ fold_xor(w);
            if (gaps && $urandom_range(99) < 20) tick_run($urandom_range(1, 3));
            pulse(ACT_RX_WORD, w);
        end
    endtask

    task automatic read_tail();
        pulse(ACT_RX_MARKER, $urandom());
        read_words($urandom_range(0, 6), $urandom_range(99) < 75, 1'b1);
        if ($urandom_range(99) < 85) pulse(ACT_RX_MARKER, $urandom());
        tick_run($urandom_range(1, 2));
    endtask

    task automatic long_read(input bit close);
        put(ACT_START_READ, $urandom(), 1'b0, '0, 1'b1);
        pulse(ACT_RX_MARKER, $urandom());
        read_words(BUF_WORDS, 1'b1, 1'b0);
        repeat (2) pulse(ACT_RX_WORD, $urandom());
        if (close) pulse(ACT_RX_MARKER, $urandom());
        pulse(ACT_TICK, $urandom());
    endtask

    task automatic random_traffic(input int n_items);
        int   stop;
        int   pick;
        logic er;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                er = 1'($urandom_range(0, 1));
                put(ACT_START_WRITE, $urandom(), er, pick_tmo(), $urandom_range(99) < 90);
                tick_run($urandom_range(0, 2));
                pulse(ACT_TX_DONE, $urandom());
                if (er) begin
                    tick_run($urandom_range(0, 2));
                    read_tail();
                end else begin
                    tick_run($urandom_range(1, 2));
                end
            end else if (pick < 75) begin
                put(ACT_START_READ, $urandom(), 1'($urandom_range(0, 1)), pick_tmo(),
                    1'($urandom_range(0, 1)));
                tick_run($urandom_range(0, 2));
                read_tail();
            end else begin
                repeat ($urandom_range(1, 3)) pulse(3'($urandom_range(0, 5)), $urandom());
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
    endtask

    task automatic set_config(input logic net, input logic [GAP_W-1:0] gap_lim,
                              input logic [TIMER_W-1:0] wr_lim);
        reg_idx_t           idx[3];
        logic [CFG_DAT_W-1:0] val[3];
        idx[0] = REG_NET_ORDER;   val[0] = CFG_DAT_W'(net);
        idx[1] = REG_INTER_WORD;  val[1] = CFG_DAT_W'(gap_lim);
        idx[2] = REG_WRITE_LIMIT; val[2] = wr_lim;
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
            cfg_writes++;
        end
        cfg_valid   <= 1'b0;
        reg_net     = net;
        reg_gap_lim = gap_lim;
        reg_wr_lim  = wr_lim;
    endtask

    function automatic void plan_add(input logic [ACTION_W-1:0] act,
                                     input logic [WORD_W-1:0] data, input logic er,
                                     input logic [TIMER_W-1:0] tmo, input logic lines);
        plan_row_t row;
        row.act = act; row.data = data; row.er = er; row.tmo = tmo; row.lines = lines;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_chk(input logic [ACTION_W-1:0] act,
                                     input logic [WORD_W-1:0] data, input logic er,
                                     input logic [TIMER_W-1:0] tmo, input logic lines,
                                     input logic acc, input phase_t ph, input outcome_t oc,
                                     input failure_t fl);
        plan_row_t row;
        row.act = act; row.data = data; row.er = er; row.tmo = tmo; row.lines = lines;
        row.typed = 1'b1;
        row.want  = '0;
        row.want.accepted = acc;
        row.want.phase    = ph;
        row.want.outcome  = oc;
        row.want.failure  = fl;
        plan.push_back(row);
    endfunction

    // ---------------- receiver ----------------

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len - 1) @(posedge aclk);
                hold_len = 0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------- checker ----------------

    always @(posedge aclk) begin : status_check
        result_t got;
        result_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[17:0]);
            if (pending_status.size() == 0) begin
                $error("status result with no transaction pending: %h", m_tdata);
                mismatches++;
            end else begin
                exp = pending_status.pop_front();
                results_checked++;
                oc_seen[exp.outcome]++;
                fl_seen[exp.failure]++;
                if (got.accepted !== exp.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp.accepted, got.accepted);
                    mismatches++;
                end
                if (got.phase !== exp.phase) begin
                    $error("phase: expected %0d, got %0d", exp.phase, got.phase);
                    mismatches++;
                end
                if (got.outcome !== exp.outcome) begin
                    $error("outcome: expected %0d, got %0d", exp.outcome, got.outcome);
                    mismatches++;
                end
                if (got.failure !== exp.failure) begin
                    $error("failure: expected %0d, got %0d", exp.failure, got.failure);
                    mismatches++;
                end
                if (got.packet_words !== exp.packet_words) begin
                    $error("packet_words: expected %0d, got %0d",
                           exp.packet_words, got.packet_words);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_status.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin
        // idle-phase strays, refused starts and spare action codes
        plan_chk(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        plan_chk(ACT_TX_DONE,     32'h0,        1'b1, 24'hFFFFFF, 1'b1,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        plan_chk(ACT_RX_WORD,     32'hFFFFFFFF, 1'b0, 24'h0,      1'b0,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        plan_chk(ACT_RX_MARKER,   32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        plan_chk(ACT_RSVD_6,      32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 1'b1,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        plan_chk(ACT_RSVD_7,      32'h0,        1'b1, 24'hFFFFFF, 1'b1,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        plan_chk(ACT_START_WRITE, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 1'b0,
                 1'b0, PH_IDLE, OC_NONE, FL_NONE);
        // write with reply; busy starts refused; response timeout after two ticks
        plan_chk(ACT_START_WRITE, 32'h0,        1'b1, 24'd2,      1'b1,
                 1'b1, PH_WRITING, OC_NONE, FL_NONE);
        plan_chk(ACT_START_READ,  32'h0,        1'b0, 24'h0,      1'b1,
                 1'b0, PH_WRITING, OC_NONE, FL_NONE);
        plan_chk(ACT_START_WRITE, 32'h0,        1'b0, 24'h0,      1'b1,
                 1'b0, PH_WRITING, OC_NONE, FL_NONE);
        plan_chk(ACT_TX_DONE,     32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_AWAIT_READ, OC_NONE, FL_NONE);
        plan_chk(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_AWAIT_READ, OC_NONE, FL_NONE);
        plan_chk(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_IDLE, OC_READ_FAIL, FL_TIMEOUT);
        // read with no timeout, three-word packet with good length and check
        plan_chk(ACT_START_READ,  32'h0,        1'b0, 24'h0,      1'b0,
                 1'b1, PH_AWAIT_READ, OC_NONE, FL_NONE);
        plan_chk(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_AWAIT_READ, OC_NONE, FL_NONE);
        plan_chk(ACT_RX_MARKER,   32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_READING, OC_NONE, FL_NONE);
        plan_add(ACT_RX_WORD,     32'h01AABBCC, 1'b0, 24'h0,      1'b0);
        plan_add(ACT_RX_WORD,     32'h12345678, 1'b1, 24'h0,      1'b1);
        plan_add(ACT_RX_WORD,     32'hD4000000, 1'b0, 24'hFFFFFF, 1'b0);
        plan_chk(ACT_RX_MARKER,   32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_READ_DONE, OC_NONE, FL_NONE);
        plan_add(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0);
        // write without reply
        plan_chk(ACT_START_WRITE, 32'h0,        1'b0, 24'hFFFFFF, 1'b1,
                 1'b1, PH_WRITING, OC_NONE, FL_NONE);
        plan_chk(ACT_TX_DONE,     32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_WRITE_DONE, OC_NONE, FL_NONE);
        plan_chk(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_IDLE, OC_WRITE_DONE, FL_NONE);
        // empty packet
        plan_chk(ACT_START_READ,  32'h0,        1'b0, 24'hFFFFFF, 1'b0,
                 1'b1, PH_AWAIT_READ, OC_NONE, FL_NONE);
        plan_chk(ACT_RX_MARKER,   32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_READING, OC_NONE, FL_NONE);
        plan_chk(ACT_RX_MARKER,   32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_READ_DONE, OC_NONE, FL_NONE);
        plan_chk(ACT_TICK,        32'h0,        1'b0, 24'h0,      1'b0,
                 1'b0, PH_IDLE, OC_READ_FAIL, FL_MISSING);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].act, plan[i].data, plan[i].er, plan[i].tmo, plan[i].lines,
                      plan[i].typed, plan[i].want);

        // buffer full: overflow on tick, then a maximum-length good packet
        long_read(1'b0);
        long_read(1'b1);

        settle();
        set_config(1'b0, 16'd1, 24'd1);
        hold_len = 48;
        random_traffic(65);

        settle();
        set_config(1'b1, 16'hFFFF, 24'hFFFFFF);
        send_idle_pct = 77;
        random_traffic(65);

        settle();
        set_config(1'b0, 16'($urandom_range(2, 6)), 24'($urandom_range(2, 8)));
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        random_traffic(65);

        settle();
        set_config(1'b1, 16'($urandom_range(2, 6)), 24'($urandom_range(2, 8)));
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        random_traffic(65);

        settle();
        repeat (8) @(posedge aclk);

        $display("%0d transactions, %0d checked results, %0d register writes, four mixes.",
                 items_sent, results_checked, cfg_writes);
        $display("wr ok %0d fail %0d, rd ok %0d fail %0d (chk %0d miss %0d ovf %0d tmo %0d)",
                 oc_seen[OC_WRITE_DONE], oc_seen[OC_WRITE_FAIL], oc_seen[OC_READ_OK],
                 oc_seen[OC_READ_FAIL], fl_seen[FL_CHECK], fl_seen[FL_MISSING],
                 fl_seen[FL_OVERFLOW], fl_seen[FL_TIMEOUT]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
design/sbhtc_pkg.sv
design/serial_bus_host_transaction_control_core.sv
design/sbhtc_checker.sv
tb/sv/tb.sv
